FILE: src/bc_pkg.sv
// Shared types, codes and constants for the betweenness centrality block.
// No dependencies.
`default_nettype none
package bc_pkg;

  // Field widths fixed by the item format
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned FIELD_W  = 13;
  localparam int unsigned VTX_W    = 8;
  localparam int unsigned SCORE_W  = 48;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned NV_W     = 9;
  localparam int unsigned NE_W     = 13;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;
  // Multiplicand of one dependency term: 1.0 + delta, below 2^49
  localparam int unsigned TERM_W   = SCORE_W + 1;
  localparam int unsigned PROD_W   = TERM_W + COUNT_W;

  localparam int unsigned DEF_MAX_VERTICES     = 256;
  localparam int unsigned DEF_MAX_EDGES        = 4096;
  localparam int unsigned DEF_MAX_PREDECESSORS = 16;

  localparam logic [MODE_W-1:0] MODE_OFFSET = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NBR    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic REG_NV = 1'b0;
  localparam logic REG_NE = 1'b1;

  // Controller states, also the command to the datapath
  localparam int unsigned OP_W = 5;
  localparam logic [OP_W-1:0] OP_IDLE   = 5'd0;
  localparam logic [OP_W-1:0] OP_CLR    = 5'd1;
  localparam logic [OP_W-1:0] OP_INIT   = 5'd2;
  localparam logic [OP_W-1:0] OP_SEED   = 5'd3;
  localparam logic [OP_W-1:0] OP_QRD    = 5'd4;
  localparam logic [OP_W-1:0] OP_QV     = 5'd5;
  localparam logic [OP_W-1:0] OP_QRANGE = 5'd6;
  localparam logic [OP_W-1:0] OP_ERD    = 5'd7;
  localparam logic [OP_W-1:0] OP_EW     = 5'd8;
  localparam logic [OP_W-1:0] OP_EUPD   = 5'd9;
  localparam logic [OP_W-1:0] OP_RSTART = 5'd10;
  localparam logic [OP_W-1:0] OP_RRD    = 5'd11;
  localparam logic [OP_W-1:0] OP_RW     = 5'd12;
  localparam logic [OP_W-1:0] OP_RCEN   = 5'd13;
  localparam logic [OP_W-1:0] OP_PRD    = 5'd14;
  localparam logic [OP_W-1:0] OP_PP     = 5'd15;
  localparam logic [OP_W-1:0] OP_PSTART = 5'd16;
  localparam logic [OP_W-1:0] OP_PWAIT  = 5'd17;
  localparam logic [OP_W-1:0] OP_PADD   = 5'd18;
  localparam logic [OP_W-1:0] OP_NEXT   = 5'd19;
  localparam logic [OP_W-1:0] OP_DONE   = 5'd20;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            accept;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic init_last;
    logic n_zero;
    logic q_more;
    logic e_more;
    logic w_in;
    logic r_more;
    logic k_more;
    logic div_done;
    logic src_last;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/bc_muldiv.sv
// Bit-serial floor(a * b / d) with 48-bit saturation: shift-add multiply, then
// restoring divide. Depends on bc_pkg.
`default_nettype none
module bc_muldiv (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bc_pkg::TERM_W-1:0]   a_i,
  input  wire logic [bc_pkg::COUNT_W-1:0]  b_i,
  input  wire logic [bc_pkg::COUNT_W-1:0]  d_i,
  output logic                             done_o,
  output logic [bc_pkg::SCORE_W-1:0]       quot_o,
  output logic                             ovf_o
);
  import bc_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam int unsigned IT_W = $clog2(PROD_W);

  logic [1:0]         ph_q, ph_d;
  logic [IT_W-1:0]    it_q, it_d;
  logic               done_q, done_d;
  logic [PROD_W-1:0]  acc_q, acc_d;
  logic [TERM_W-1:0]  a_q, a_d;
  logic [COUNT_W-1:0] b_q, b_d;
  logic [COUNT_W-1:0] d_q, d_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic               dz_q, dz_d;
  logic [COUNT_W:0]   remx;
  logic               ge;

  always_comb begin
    ph_d   = ph_q;
    it_d   = it_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    d_d    = d_q;
    rem_d  = rem_q;
    dz_d   = dz_q;
    remx   = {rem_q, acc_q[PROD_W-1]};
    ge     = remx >= {1'b0, d_q};
    case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          ph_d  = PH_MUL;
          it_d  = '0;
          acc_d = '0;
          a_d   = a_i;
          b_d   = b_i;
          d_d   = d_i;
          dz_d  = (d_i == '0);
        end
      end
      PH_MUL: begin
        acc_d = {acc_q[PROD_W-2:0], 1'b0} + (b_q[COUNT_W-1] ? PROD_W'(a_q) : '0);
        b_d   = {b_q[COUNT_W-2:0], 1'b0};
        it_d  = it_q + 1'b1;
        if (it_q == IT_W'(COUNT_W - 1)) begin
          ph_d  = PH_DIV;
          it_d  = '0;
          rem_d = '0;
        end
      end
      PH_DIV: begin
        rem_d = ge ? COUNT_W'(remx - {1'b0, d_q}) : COUNT_W'(remx);
        acc_d = {acc_q[PROD_W-2:0], ge};
        it_d  = it_q + 1'b1;
        if (it_q == IT_W'(PROD_W - 1)) begin
          ph_d   = PH_IDLE;
          done_d = 1'b1;
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q  <= it_d;
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    d_q   <= d_d;
    rem_q <= rem_d;
    dz_q  <= dz_d;
  end

  assign done_o = done_q;
  assign ovf_o  = ~dz_q & (|acc_q[PROD_W-1:SCORE_W]);
  assign quot_o = dz_q ? '0 : (ovf_o ? {SCORE_W{1'b1}} : acc_q[SCORE_W-1:0]);

endmodule
`default_nettype wire

FILE: src/bc_ctrl.sv
// Sequencer for load, read and compute items: walks the breadth-first pass,
// the reverse pass and the dependency updates. Depends on bc_pkg.
`default_nettype none
module bc_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  input  wire logic [bc_pkg::MODE_W-1:0]  mode_i,
  input  wire bc_pkg::sts_t               sts_i,
  output bc_pkg::cmd_t                    cmd_o,
  output logic                            busy
);
  import bc_pkg::*;

  logic [OP_W-1:0] state_q, state_d;
  logic            accept;

  assign accept = start & (state_q == OP_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      OP_IDLE:   if (accept && mode_i == MODE_RUN) state_d = OP_CLR;
      OP_CLR:    if (sts_i.clr_last) state_d = sts_i.n_zero ? OP_DONE : OP_INIT;
      OP_INIT:   if (sts_i.init_last) state_d = OP_SEED;
      OP_SEED:   state_d = OP_QRD;
      OP_QRD:    state_d = sts_i.q_more ? OP_QV : OP_RSTART;
      OP_QV:     state_d = OP_QRANGE;
      OP_QRANGE: state_d = OP_ERD;
      OP_ERD:    state_d = sts_i.e_more ? OP_EW : OP_QRD;
      OP_EW:     state_d = sts_i.w_in ? OP_EUPD : OP_ERD;
      OP_EUPD:   state_d = OP_ERD;
      OP_RSTART: state_d = OP_RRD;
      OP_RRD:    state_d = sts_i.r_more ? OP_RW : OP_NEXT;
      OP_RW:     state_d = OP_RCEN;
      OP_RCEN:   state_d = OP_PRD;
      OP_PRD:    state_d = sts_i.k_more ? OP_PP : OP_RRD;
      OP_PP:     state_d = OP_PSTART;
      OP_PSTART: state_d = OP_PWAIT;
      OP_PWAIT:  if (sts_i.div_done) state_d = OP_PADD;
      OP_PADD:   state_d = OP_PRD;
      OP_NEXT:   state_d = sts_i.src_last ? OP_DONE : OP_INIT;
      OP_DONE:   state_d = OP_IDLE;
      default:   state_d = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OP_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.op     = state_q;
  assign cmd_o.accept = accept;
  assign busy         = (state_q != OP_IDLE);

endmodule
`default_nettype wire

FILE: src/bc_dp.sv
// Datapath: graph, per-source and score memories, walk counters, saturating
// adders and the serial term unit. Depends on bc_pkg and bc_muldiv.
`default_nettype none
module bc_dp #(
  parameter int unsigned MAX_VERTICES     = bc_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MAX_EDGES        = bc_pkg::DEF_MAX_EDGES,
  parameter int unsigned MAX_PREDECESSORS = bc_pkg::DEF_MAX_PREDECESSORS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bc_pkg::cmd_t                cmd_i,
  input  wire logic [bc_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [bc_pkg::FIELD_W-1:0]  index_i,
  input  wire logic [bc_pkg::FIELD_W-1:0]  load_value_i,
  input  wire logic [bc_pkg::NV_W-1:0]     nv_i,
  input  wire logic [bc_pkg::NE_W-1:0]     ne_i,
  output bc_pkg::sts_t                     sts_o,
  output logic                             done_o,
  output logic                             kind_o,
  output logic [bc_pkg::VTX_W-1:0]         vertex_o,
  output logic [bc_pkg::SCORE_W-1:0]       score_o,
  output logic                             overflow_o
);
  import bc_pkg::*;

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned NW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned RW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW  = $clog2(MAX_EDGES);
  localparam int unsigned KW  = $clog2(MAX_PREDECESSORS + 1);
  localparam int unsigned PD  = MAX_VERTICES * MAX_PREDECESSORS;
  localparam int unsigned PAW = $clog2(PD);
  localparam int unsigned DW  = VW + 1;

  // memories
  logic [FIELD_W-1:0] row_mem  [MAX_VERTICES+1];
  logic [FIELD_W-1:0] nbr_mem  [MAX_EDGES];
  logic [DW-1:0]      dist_mem [MAX_VERTICES];
  logic [COUNT_W-1:0] pc_mem   [MAX_VERTICES];
  logic [KW-1:0]      pn_mem   [MAX_VERTICES];
  logic [SCORE_W-1:0] dep_mem  [MAX_VERTICES];
  logic [SCORE_W-1:0] cent_mem [MAX_VERTICES];
  logic [VW-1:0]      q_mem    [MAX_VERTICES];
  logic [VW-1:0]      pred_mem [PD];

  logic [FIELD_W-1:0] row_rd0, row_rd1, nbr_rd;
  logic [DW-1:0]      dist_rd;
  logic [COUNT_W-1:0] pc_rd;
  logic [KW-1:0]      pn_rd;
  logic [SCORE_W-1:0] dep_rd, cent_rd;
  logic [VW-1:0]      q_rd, pred_rd;

  // registers
  logic [NW-1:0]      cnt_q, cnt_d;
  logic [VW-1:0]      src_q, src_d;
  logic [NW-1:0]      head_q, head_d, tail_q, tail_d, depth_q, depth_d;
  logic [VW-1:0]      v_q, v_d, w_q, w_d, p_q, p_d;
  logic [FIELD_W-1:0] j_q, j_d, end_q, end_d;
  logic [VW-1:0]      dv_q, dv_d;
  logic [COUNT_W-1:0] sv_q, sv_d, sw_q, sw_d;
  logic [SCORE_W-1:0] dw_q, dw_d, depp_q, depp_d;
  logic [KW-1:0]      k_q, k_d, pn_q, pn_d;
  logic               ovf_q, ovf_d;
  logic               rdp_q, rdp_d;
  logic               inr_q, inr_d;
  logic [VTX_W-1:0]   vtx_q, vtx_d;
  // scores memory holds nothing until the first compute clears it
  logic               cent_ok_q, cent_ok_d;

  // write ports and read addresses
  logic               row_we, nbr_we, dist_we, pc_we, pn_we, dep_we, cent_we, q_we, pred_we;
  logic [RW-1:0]      row_wa, row_ra1;
  logic [EW-1:0]      nbr_wa;
  logic [VW-1:0]      dist_wa, pc_wa, pn_wa, dep_wa, cent_wa, q_wa;
  logic [PAW-1:0]     pred_wa, pred_ra;
  logic [DW-1:0]      dist_wd;
  logic [COUNT_W-1:0] pc_wd;
  logic [KW-1:0]      pn_wd;
  logic [SCORE_W-1:0] dep_wd, cent_wd;
  logic [VW-1:0]      q_wa_d, pred_wd;
  logic [VW-1:0]      va_ra, cent_ra, q_ra, dep_ra;

  logic [NW-1:0]      n_w;
  logic [FIELD_W-1:0] edge_lim;
  logic [DW-1:0]      dplus;
  logic               unseen, eqd;
  logic [COUNT_W:0]   pc_sum;
  logic [SCORE_W:0]   cent_sum, dep_sum;
  logic               md_start, md_done, md_ovf;
  logic [SCORE_W-1:0] md_quot;

  assign n_w = (32'(nv_i) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(nv_i);
  assign edge_lim = (32'(ne_i) > MAX_EDGES) ? FIELD_W'(MAX_EDGES) : FIELD_W'(ne_i);
  // one bit wider so the deepest level cannot wrap onto the source
  assign dplus    = {1'b0, dv_q} + 1'b1;
  assign unseen   = ~dist_rd[VW];
  assign eqd      = unseen | ({1'b0, dist_rd[VW-1:0]} == dplus);
  assign pc_sum   = {1'b0, pc_rd} + {1'b0, sv_q};
  assign cent_sum = {1'b0, cent_rd} + {1'b0, dep_rd};
  assign dep_sum  = {1'b0, depp_q} + {1'b0, md_quot};
  assign md_start = (cmd_i.op == OP_PSTART);

  always_comb begin
    sts_o.clr_last  = (cnt_q == NW'(MAX_VERTICES - 1));
    sts_o.init_last = (cnt_q == n_w - 1'b1);
    sts_o.n_zero    = (n_w == '0);
    sts_o.q_more    = (head_q < tail_q) && (32'(head_q) < MAX_VERTICES);
    sts_o.e_more    = (j_q < end_q);
    sts_o.w_in      = (32'(nbr_rd) < 32'(n_w));
    sts_o.r_more    = (depth_q != '0);
    sts_o.k_more    = (k_q < pn_q);
    sts_o.div_done  = md_done;
    sts_o.src_last  = (NW'(src_q) == n_w - 1'b1);
  end

  always_comb begin
    cnt_d = cnt_q;   src_d = src_q;   head_d = head_q; tail_d = tail_q;
    depth_d = depth_q; v_d = v_q;     w_d = w_q;       p_d = p_q;
    j_d = j_q;       end_d = end_q;   dv_d = dv_q;     sv_d = sv_q;
    sw_d = sw_q;     dw_d = dw_q;     depp_d = depp_q; k_d = k_q;
    pn_d = pn_q;     ovf_d = ovf_q;   rdp_d = 1'b0;    inr_d = inr_q;
    vtx_d = vtx_q;   cent_ok_d = cent_ok_q;

    row_we = 1'b0; nbr_we = 1'b0; dist_we = 1'b0; pc_we = 1'b0; pn_we = 1'b0;
    dep_we = 1'b0; cent_we = 1'b0; q_we = 1'b0; pred_we = 1'b0;
    row_wa  = RW'(index_i);
    nbr_wa  = EW'(index_i);
    dist_wa = VW'(cnt_q); pc_wa = VW'(cnt_q); pn_wa = VW'(cnt_q); dep_wa = VW'(cnt_q);
    cent_wa = VW'(cnt_q); q_wa = VW'(tail_q);
    dist_wd = '0; pc_wd = '0; pn_wd = '0; dep_wd = '0; cent_wd = '0; q_wa_d = w_q;
    pred_wa = PAW'(w_q) * PAW'(MAX_PREDECESSORS) + PAW'(pn_rd);
    pred_wd = v_q;
    pred_ra = PAW'(w_q) * PAW'(MAX_PREDECESSORS) + PAW'(k_q);
    va_ra   = w_q;
    dep_ra  = w_q;
    cent_ra = VW'(index_i);
    q_ra    = VW'(head_q);
    row_ra1 = RW'(q_rd) + 1'b1;

    case (cmd_i.op)
      OP_IDLE: begin
        if (cmd_i.accept) begin
          case (mode_i)
            MODE_OFFSET: row_we = (32'(index_i) <= MAX_VERTICES);
            MODE_NBR:    nbr_we = (32'(index_i) < MAX_EDGES);
            MODE_RUN: begin
              cnt_d     = '0;
              ovf_d     = 1'b0;
              src_d     = '0;
              cent_ok_d = 1'b1;
            end
            MODE_READ: begin
              rdp_d = 1'b1;
              inr_d = (32'(index_i) < MAX_VERTICES) && cent_ok_q;
              vtx_d = VTX_W'(index_i);
            end
            default: ;
          endcase
        end
      end
      OP_CLR: begin
        cent_we = 1'b1;
        cnt_d   = sts_o.clr_last ? '0 : cnt_q + 1'b1;
      end
      OP_INIT: begin
        dist_we = 1'b1; pc_we = 1'b1; pn_we = 1'b1; dep_we = 1'b1;
        cnt_d   = sts_o.init_last ? '0 : cnt_q + 1'b1;
      end
      OP_SEED: begin
        dist_we = 1'b1; dist_wa = src_q; dist_wd = {1'b1, {VW{1'b0}}};
        pc_we   = 1'b1; pc_wa = src_q;   pc_wd = COUNT_W'(1);
        q_we    = 1'b1; q_wa = '0;       q_wa_d = src_q;
        head_d  = '0;
        tail_d  = NW'(1);
      end
      OP_QRD: q_ra = VW'(head_q);
      OP_QV: begin
        v_d    = q_rd;
        va_ra  = q_rd;
        head_d = head_q + 1'b1;
      end
      OP_QRANGE: begin
        j_d   = row_rd0;
        end_d = (row_rd1 > edge_lim) ? edge_lim : row_rd1;
        dv_d  = dist_rd[VW-1:0];
        sv_d  = pc_rd;
      end
      OP_EW: begin
        w_d   = VW'(nbr_rd);
        va_ra = VW'(nbr_rd);
        j_d   = j_q + 1'b1;
      end
      OP_EUPD: begin
        if (unseen) begin
          dist_we = 1'b1; dist_wa = w_q; dist_wd = {1'b1, dplus[VW-1:0]};
          if (32'(tail_q) < MAX_VERTICES) begin
            q_we   = 1'b1;
            tail_d = tail_q + 1'b1;
          end
        end
        if (eqd) begin
          pc_we = 1'b1; pc_wa = w_q;
          pc_wd = pc_sum[COUNT_W] ? {COUNT_W{1'b1}} : pc_sum[COUNT_W-1:0];
          if (pc_sum[COUNT_W]) ovf_d = 1'b1;
          if (32'(pn_rd) < MAX_PREDECESSORS) begin
            pred_we = 1'b1;
            pn_we   = 1'b1; pn_wa = w_q; pn_wd = pn_rd + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      OP_RSTART: depth_d = head_q;
      OP_RRD: begin
        q_ra = VW'(depth_q - 1'b1);
        if (depth_q != '0) depth_d = depth_q - 1'b1;
      end
      OP_RW: begin
        w_d     = q_rd;
        va_ra   = q_rd;
        dep_ra  = q_rd;
        cent_ra = q_rd;
      end
      OP_RCEN: begin
        dw_d = dep_rd;
        sw_d = pc_rd;
        pn_d = pn_rd;
        k_d  = '0;
        if (w_q != src_q) begin
          cent_we = 1'b1; cent_wa = w_q;
          cent_wd = cent_sum[SCORE_W] ? {SCORE_W{1'b1}} : cent_sum[SCORE_W-1:0];
          if (cent_sum[SCORE_W]) ovf_d = 1'b1;
        end
      end
      OP_PP: begin
        p_d    = pred_rd;
        va_ra  = pred_rd;
        dep_ra = pred_rd;
      end
      OP_PSTART: depp_d = dep_rd;
      OP_PADD: begin
        dep_we = 1'b1; dep_wa = p_q;
        dep_wd = dep_sum[SCORE_W] ? {SCORE_W{1'b1}} : dep_sum[SCORE_W-1:0];
        if (dep_sum[SCORE_W] || md_ovf) ovf_d = 1'b1;
        k_d = k_q + 1'b1;
      end
      OP_NEXT: begin
        src_d = src_q + 1'b1;
        cnt_d = '0;
      end
      default: ;
    endcase
  end

  // graph memories
  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_wa] <= load_value_i;
    row_rd0 <= row_mem[RW'(q_rd)];
    row_rd1 <= row_mem[row_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (nbr_we) nbr_mem[nbr_wa] <= load_value_i;
    nbr_rd <= nbr_mem[EW'(j_q)];
  end

  // per-source and score memories
  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_rd <= dist_mem[va_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pc_we) pc_mem[pc_wa] <= pc_wd;
    pc_rd <= pc_mem[va_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pn_we) pn_mem[pn_wa] <= pn_wd;
    pn_rd <= pn_mem[va_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dep_we) dep_mem[dep_wa] <= dep_wd;
    dep_rd <= dep_mem[dep_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cent_we) cent_mem[cent_wa] <= cent_wd;
    cent_rd <= cent_mem[cent_ra];
  end

  // walk queue; read backwards it is the visit stack
  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_wa] <= q_wa_d;
    q_rd <= q_mem[q_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pred_we) pred_mem[pred_wa] <= pred_wd;
    pred_rd <= pred_mem[pred_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q     <= 1'b0;
      rdp_q     <= 1'b0;
      cent_ok_q <= 1'b0;
    end else begin
      ovf_q     <= ovf_d;
      rdp_q     <= rdp_d;
      cent_ok_q <= cent_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;   src_q <= src_d;   head_q <= head_d; tail_q <= tail_d;
    depth_q <= depth_d; v_q <= v_d;     w_q <= w_d;       p_q <= p_d;
    j_q <= j_d;       end_q <= end_d;   dv_q <= dv_d;     sv_q <= sv_d;
    sw_q <= sw_d;     dw_q <= dw_d;     depp_q <= depp_d; k_q <= k_d;
    pn_q <= pn_d;     inr_q <= inr_d;   vtx_q <= vtx_d;
  end

  bc_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (TERM_W'(dw_q) + (TERM_W'(1) << FRAC_W)),
    .b_i     (pc_rd),
    .d_i     (sw_q),
    .done_o  (md_done),
    .quot_o  (md_quot),
    .ovf_o   (md_ovf)
  );

  assign done_o     = rdp_q | (cmd_i.op == OP_DONE);
  assign kind_o     = rdp_q ? KIND_READ : KIND_DONE;
  assign vertex_o   = rdp_q ? vtx_q : '0;
  assign score_o    = (rdp_q && inr_q) ? cent_rd : '0;
  assign overflow_o = ovf_q;

endmodule
`default_nettype wire

FILE: src/betweenness_centrality.sv
// Top level: configuration registers and the controller/datapath pair.
// Depends on bc_pkg, bc_ctrl, bc_dp (and bc_muldiv below it).
//
// Usage. Items enter on start with mode_i, index_i and load_value_i and are
// taken when start is high and busy is low. Offset and neighbour words
// (modes 0, 1) are written and give no result. A score read (mode 3) is
// answered in the cycle after it is taken; reads and loads may follow one
// another every cycle. A compute word (mode 2) raises busy until done_o
// reports kind 0: it clears the scores, then per source resets the
// per-vertex state, walks the graph breadth-first, runs the reverse pass
// and forms the dependency term of each stored predecessor with the
// bit-serial multiply-divide.
// Each result is shown on done_o for one cycle; the receiver cannot stall.
// Reset clears the controller and overflow flag and sets num_vertices to 1,
// num_edges to 0; the graph memories hold nothing until loaded.
// Configuration sits on an APB-style port: num_vertices at 0, num_edges at 4.
`default_nettype none
module betweenness_centrality #(
  parameter int unsigned MAX_VERTICES     = bc_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MAX_EDGES        = bc_pkg::DEF_MAX_EDGES,
  parameter int unsigned MAX_PREDECESSORS = bc_pkg::DEF_MAX_PREDECESSORS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bc_pkg::DATA_W-1:0]   pwdata,
  output logic [bc_pkg::DATA_W-1:0]        prdata,
  output logic                             pready,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [bc_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [bc_pkg::FIELD_W-1:0]  index_i,
  input  wire logic [bc_pkg::FIELD_W-1:0]  load_value_i,
  output logic                             done_o,
  output logic                             kind_o,
  output logic [bc_pkg::VTX_W-1:0]         vertex_o,
  output logic [bc_pkg::SCORE_W-1:0]       score_o,
  output logic                             overflow_o
);
  import bc_pkg::*;

  logic [NV_W-1:0] nv_q;
  logic [NE_W-1:0] ne_q;
  logic            wr;
  logic            reg_sel;
  cmd_t            cmd;
  sts_t            sts;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_NV) ? DATA_W'(nv_q) : DATA_W'(ne_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= NV_W'(1);
      ne_q <= '0;
    end else if (wr) begin
      if (reg_sel == REG_NV) nv_q <= pwdata[NV_W-1:0];
      else                   ne_q <= pwdata[NE_W-1:0];
    end
  end

  bc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  bc_dp #(
    .MAX_VERTICES     (MAX_VERTICES),
    .MAX_EDGES        (MAX_EDGES),
    .MAX_PREDECESSORS (MAX_PREDECESSORS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (mode_i),
    .index_i      (index_i),
    .load_value_i (load_value_i),
    .nv_i         (nv_q),
    .ne_i         (ne_q),
    .sts_o        (sts),
    .done_o       (done_o),
    .kind_o       (kind_o),
    .vertex_o     (vertex_o),
    .score_o      (score_o),
    .overflow_o   (overflow_o)
  );

endmodule
`default_nettype wire
